>>> rtl/sclru_pkg.sv
// Package for the sector cache LRU directory.
// Transaction payload types and operation codes; no dependencies.
`default_nettype none
package sclru_pkg;

	localparam logic [1:0] FUNC_LOOKUP     = 2'd0;
	localparam logic [1:0] FUNC_FILL       = 2'd1;
	localparam logic [1:0] FUNC_INVALIDATE = 2'd2;

	localparam int SECTOR_W = 32;
	localparam int STAMP_W  = 32;
	localparam int SLOT_W   = 3;

	typedef struct packed {
		logic [1:0]          func;
		logic                drive;
		logic [SECTOR_W-1:0] sector;
		logic [7:0]          count;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot;
		logic              evicted;
	} rsp_t;

endpackage
`default_nettype wire

>>> rtl/sclru_stream_if.sv
// Valid/ready stream interface carrying one payload per transaction.
// Payload type is a parameter; used with sclru_pkg types.
`default_nettype none
interface sclru_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/sclru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sclru_ram #(
	parameter int W = 32,
	parameter int D = 8
) (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                      wdata,
	input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
	output      logic [W-1:0]                      rdata
);

	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/sector_cache_lru_directory_unit.sv
// Sector cache LRU directory: one transaction in, one result out.
// A lookup miss, a fill that evicts and an invalidate scan all SLOTS slots; a hit or a free slot ends
// the scan at that slot, and an unused func code skips the scan. One transaction at a time: the scan reads
// one slot per cycle from the tag and stamp RAMs through a single compare unit, so the next request is
// taken only once the last result has gone to the output register; a result still held stalls the update.
// Reset (arst_n low): all slots invalid, access counter zero, no result pending.
`default_nettype none
module sector_cache_lru_directory_unit #(
	parameter int SLOTS = 8
) (
	input wire logic     clk,
	input wire logic     arst_n,
	sclru_stream_if.sink   req,
	sclru_stream_if.source rsp
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);
	localparam int TAG_W = sclru_pkg::SECTOR_W + 1;

	// sequencer states
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;

	logic [1:0] state_q;

	// captured transaction
	logic [1:0]                     func_q;
	logic                           drv_q;
	logic [sclru_pkg::SECTOR_W-1:0] sec_q;
	logic [sclru_pkg::SECTOR_W-1:0] top_q;   // sector + count, wraps mod 2^32

	// scan pointers: addr_q issues reads, chk_idx_s1 is the slot whose data is back
	logic [IW-1:0] addr_q;
	logic          issue_q;
	logic [IW-1:0] chk_idx_s1;
	logic          chk_vld_s1;

	// directory state
	logic [SLOTS-1:0]              valid_q;
	logic [sclru_pkg::STAMP_W-1:0] cnt_q;

	// replacement search
	logic [sclru_pkg::STAMP_W-1:0] min_q;
	logic [IW-1:0]                 old_q;

	// result being built
	logic [IW-1:0] wr_idx_q;
	logic          do_wr_q;
	logic          hit_q;
	logic          evict_q;

	// output register
	logic          rsp_vld_q;
	sclru_pkg::rsp_t rsp_q;

	// RAM read data for chk_idx_s1
	logic [TAG_W-1:0]              tag_rd;
	logic [sclru_pkg::STAMP_W-1:0] stamp_rd;

	logic upd_go;
	logic tag_we;
	logic stamp_we;
	logic [sclru_pkg::STAMP_W-1:0] next_stamp;

	// per-slot compare unit, shared by all three operations
	logic slot_v;
	logic drv_eq;
	logic sec_eq;
	logic sec_ge;
	logic sec_lt;
	logic stamp_lt;
	logic hit_now;
	logic free_now;
	logic older;
	logic clr_now;
	logic last_now;

	always_comb begin
		slot_v   = valid_q[chk_idx_s1];
		drv_eq   = tag_rd[TAG_W-1] == drv_q;
		sec_eq   = tag_rd[sclru_pkg::SECTOR_W-1:0] == sec_q;
		sec_ge   = tag_rd[sclru_pkg::SECTOR_W-1:0] >= sec_q;
		sec_lt   = tag_rd[sclru_pkg::SECTOR_W-1:0] < top_q;
		stamp_lt = stamp_rd < min_q;
		hit_now  = chk_vld_s1 && slot_v && drv_eq && sec_eq;
		free_now = chk_vld_s1 && !slot_v;
		// slot 0 seeds the running minimum
		older    = (chk_idx_s1 == '0) || stamp_lt;
		clr_now  = chk_vld_s1 && slot_v && drv_eq && sec_ge && sec_lt;
		last_now = chk_vld_s1 && (chk_idx_s1 == LAST);
	end

	// result leaves only when the output register is free
	assign upd_go     = (state_q == S_UPD) && (!rsp_vld_q || rsp.ready);
	assign stamp_we   = upd_go && do_wr_q;
	assign tag_we     = stamp_we && (func_q == sclru_pkg::FUNC_FILL);
	assign next_stamp = cnt_q + sclru_pkg::STAMP_W'(1);

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = rsp_vld_q;
	assign rsp.data  = rsp_q;

	sclru_ram #(.W(TAG_W), .D(SLOTS)) u_tag_ram (
		.clk   (clk),
		.we    (tag_we),
		.waddr (wr_idx_q),
		.wdata ({drv_q, sec_q}),
		.raddr (addr_q),
		.rdata (tag_rd)
	);

	sclru_ram #(.W(sclru_pkg::STAMP_W), .D(SLOTS)) u_stamp_ram (
		.clk   (clk),
		.we    (stamp_we),
		.waddr (wr_idx_q),
		.wdata (next_stamp),
		.raddr (addr_q),
		.rdata (stamp_rd)
	);

	// payload captures, no reset
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_q <= req.data.func;
			drv_q  <= req.data.drive;
			sec_q  <= req.data.sector;
			top_q  <= req.data.sector + sclru_pkg::SECTOR_W'(req.data.count);
		end
		if (state_q == S_SCAN && chk_vld_s1) begin
			chk_idx_s1 <= addr_q;
		end else if (issue_q) begin
			chk_idx_s1 <= addr_q;
		end
		if (state_q == S_SCAN && chk_vld_s1 && func_q == sclru_pkg::FUNC_FILL &&
			!free_now && older) begin
			min_q <= stamp_rd;
			old_q <= chk_idx_s1;
		end
		if (upd_go) begin
			rsp_q.hit     <= hit_q;
			rsp_q.slot    <= do_wr_q ? sclru_pkg::SLOT_W'(wr_idx_q) : '0;
			rsp_q.evicted <= evict_q;
		end
	end

	// sequencer and directory control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			addr_q     <= '0;
			issue_q    <= 1'b0;
			chk_vld_s1 <= 1'b0;
			valid_q    <= '0;
			cnt_q      <= '0;
			wr_idx_q   <= '0;
			do_wr_q    <= 1'b0;
			hit_q      <= 1'b0;
			evict_q    <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						addr_q     <= '0;
						chk_vld_s1 <= 1'b0;
						do_wr_q    <= 1'b0;
						hit_q      <= 1'b0;
						evict_q    <= 1'b0;
						case (req.data.func)
							sclru_pkg::FUNC_LOOKUP,
							sclru_pkg::FUNC_FILL,
							sclru_pkg::FUNC_INVALIDATE: begin
								issue_q <= 1'b1;
								state_q <= S_SCAN;
							end
							default: begin
								// unused code: no scan, all-zero result
								issue_q <= 1'b0;
								state_q <= S_UPD;
							end
						endcase
					end
				end

				S_SCAN: begin
					// read issue, one slot per cycle
					chk_vld_s1 <= issue_q;
					if (issue_q) begin
						if (addr_q == LAST) begin
							issue_q <= 1'b0;
						end else begin
							addr_q <= addr_q + IW'(1);
						end
					end

					if (chk_vld_s1) begin
						case (func_q)
							sclru_pkg::FUNC_LOOKUP: begin
								if (hit_now) begin
									wr_idx_q <= chk_idx_s1;
									hit_q    <= 1'b1;
									do_wr_q  <= 1'b1;
								end
								if (hit_now || last_now) begin
									state_q    <= S_UPD;
									issue_q    <= 1'b0;
									chk_vld_s1 <= 1'b0;
								end
							end
							sclru_pkg::FUNC_FILL: begin
								if (free_now) begin
									wr_idx_q   <= chk_idx_s1;
									do_wr_q    <= 1'b1;
									state_q    <= S_UPD;
									issue_q    <= 1'b0;
									chk_vld_s1 <= 1'b0;
								end else if (last_now) begin
									wr_idx_q   <= older ? chk_idx_s1 : old_q;
									evict_q    <= 1'b1;
									do_wr_q    <= 1'b1;
									state_q    <= S_UPD;
									chk_vld_s1 <= 1'b0;
								end
							end
							sclru_pkg::FUNC_INVALIDATE: begin
								if (clr_now) begin
									valid_q[chk_idx_s1] <= 1'b0;
								end
								if (last_now) begin
									state_q    <= S_UPD;
									chk_vld_s1 <= 1'b0;
								end
							end
							default: begin
								state_q    <= S_UPD;
								issue_q    <= 1'b0;
								chk_vld_s1 <= 1'b0;
							end
						endcase
					end
				end

				S_UPD: begin
					if (upd_go) begin
						rsp_vld_q <= 1'b1;
						state_q   <= S_IDLE;
						if (stamp_we) begin
							cnt_q <= next_stamp;
						end
						if (tag_we) begin
							valid_q[wr_idx_q] <= 1'b1;
						end
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// RAM writes happen only while the result is handed over
	a_wr_in_upd: assert property (@(posedge clk) disable iff (!arst_n)
		stamp_we |-> (state_q == S_UPD))
		else $error("stamp write outside update");

	// counter moves only with a stamp write
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(cnt_q) |-> $past(stamp_we))
		else $error("access counter moved without a stamp write");

	// a result is never both a hit and an eviction
	a_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_vld_q |-> !(rsp_q.hit && rsp_q.evicted))
		else $error("hit and evicted together");

	// returned read data is examined only during a scan
	a_chk_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (state_q == S_SCAN))
		else $error("slot check outside scan");

	// a fill always leaves its slot valid
	a_fill_valid: assert property (@(posedge clk) disable iff (!arst_n)
		tag_we |=> valid_q[$past(wr_idx_q)])
		else $error("filled slot not valid");

endmodule
`default_nettype wire
